// File: hw/rtl/three_level_fifo_cache_lookup_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-level FIFO cache lookup
// Shorthand for clocked implications, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_FIFO_CACHE_LOOKUP_ASSERT_SVH
`define THREE_LEVEL_FIFO_CACHE_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFLC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tflc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TFLC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tflc: next-cycle check failed");

`endif

// File: hw/rtl/tflc_pkg.sv
// ----------------------------------------------------------------------------
// tflc_pkg
// Shared sizes, level codes, beat types and the access cost table.
// ----------------------------------------------------------------------------
package tflc_pkg;

	localparam int KEY_BITS   = 16;
	localparam int KEY_W      = (KEY_BITS < 16) ? KEY_BITS : 16;

	localparam int L1_DEPTH   = 5;
	localparam int L2_DEPTH   = 20;
	localparam int L3_DEPTH   = 200;
	localparam int MAIN_DEPTH = 500;

	localparam int L1_AW   = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
	localparam int L2_AW   = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;
	localparam int L3_AW   = (L3_DEPTH > 1) ? $clog2(L3_DEPTH) : 1;
	localparam int MAIN_AW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;

	localparam int L1_FW   = $clog2(L1_DEPTH + 1);
	localparam int L2_FW   = $clog2(L2_DEPTH + 1);
	localparam int L3_FW   = $clog2(L3_DEPTH + 1);
	localparam int MAIN_FW = $clog2(MAIN_DEPTH + 1);

	localparam int MAX_12    = (L1_DEPTH > L2_DEPTH) ? L1_DEPTH : L2_DEPTH;
	localparam int MAX_3M    = (L3_DEPTH > MAIN_DEPTH) ? L3_DEPTH : MAIN_DEPTH;
	localparam int MAX_DEPTH = (MAX_12 > MAX_3M) ? MAX_12 : MAX_3M;
	localparam int IDX_W     = $clog2(MAX_DEPTH + 1);

	localparam logic [15:0] BACKING_TOP_RESET = 16'd5000;

	// Costs in tenths of a unit.
	localparam int COST_CACHE   = 1;
	localparam int COST_MAIN    = 10;
	localparam int COST_BACKING = 30;

	typedef enum logic [2:0] {
		LVL_FIRST   = 3'd0,
		LVL_SECOND  = 3'd1,
		LVL_THIRD   = 3'd2,
		LVL_MAIN    = 3'd3,
		LVL_BACKING = 3'd4,
		LVL_NONE    = 3'd5
	} hit_level_t;

	typedef struct packed {
		logic [15:0] key;
		logic        func;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  hit_level;
		logic [5:0]  access_time;
		logic [16:0] operand_sum;
		logic [31:0] hits_first;
		logic [31:0] hits_second;
		logic [31:0] hits_third;
	} out_beat_t;

	function automatic logic [5:0] access_cost(input logic [2:0] level);
		logic [5:0] cost;
		unique case (level)
			LVL_FIRST:  cost = 6'(COST_CACHE);
			LVL_SECOND: cost = 6'(2 * COST_CACHE);
			LVL_THIRD:  cost = 6'(3 * COST_CACHE);
			LVL_MAIN:   cost = 6'(3 * COST_CACHE + COST_MAIN);
			default:    cost = 6'(3 * COST_CACHE + COST_MAIN + COST_BACKING);
		endcase
		return cost;
	endfunction

endpackage

// File: hw/rtl/three_level_fifo_cache_lookup.sv
// ----------------------------------------------------------------------------
// three_level_fifo_cache_lookup
// Key lookup through three FIFO-filled fully associative cache levels, a main
// store and a backing store, with fill-up of the levels above a hit.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                  Handshake
//  -------   ---------------------  -----------------------------------------
//  command   start, cmd, busy       beat taken at a clock edge with start high
//                                   and busy low
//  result    done, rsp              one beat per command, valid for exactly the
//                                   one cycle in which done is high
//  register  wr_en, wr_data         backing_top written at an edge with wr_en high
//
// Lookup: a key that is zero or above backing_top is reported in the cycle
// after it is taken and the block stays free. Any other key is searched by a
// single shared comparator that looks at one stored entry per clock while the
// current level has filled entries left, level by level; the walk stops at the
// first hit, and a key missed in the main store is found in the backing store.
// Reset: arst_n clears all control state and the fill counts; stores are not
// swept, since an entry at or beyond its level's fill count is never compared.
// Stalls: none on the result side; busy holds commands off while a search runs.
//
module three_level_fifo_cache_lookup
	import tflc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  in_beat_t    cmd,
	output logic        busy,
	input  logic        wr_en,
	input  logic [15:0] wr_data,
	output logic        done,
	output out_beat_t   rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t            state_q;
	hit_level_t        lvl_q;       // level being walked
	hit_level_t        lvl_s1;      // level of the entry being compared
	hit_level_t        hit_lvl_q;   // outcome once the walk ends
	logic [IDX_W-1:0]  idx_q;
	logic              v_s1;
	logic [KEY_W-1:0]  key_q;
	logic              func_q;
	logic [15:0]       backing_top_q;

	logic [L1_AW-1:0]   l1_ptr_q;
	logic [L2_AW-1:0]   l2_ptr_q;
	logic [L3_AW-1:0]   l3_ptr_q;
	logic [MAIN_AW-1:0] main_ptr_q;
	logic [L1_FW-1:0]   l1_fill_q;
	logic [L2_FW-1:0]   l2_fill_q;
	logic [L3_FW-1:0]   l3_fill_q;
	logic [MAIN_FW-1:0] main_fill_q;

	logic [15:0] op_a_q;
	logic [15:0] op_b_q;
	logic [31:0] hits1_q;
	logic [31:0] hits2_q;
	logic [31:0] hits3_q;
	logic        done_q;
	out_beat_t   rsp_q;

	logic [KEY_W-1:0]   key_in;
	logic               key_bad;
	logic [IDX_W-1:0]   cur_fill;
	logic               issue;
	logic               hit;
	logic [KEY_W-1:0]   rd_sel;
	logic [KEY_W-1:0]   l1_rd;
	logic [KEY_W-1:0]   l2_rd;
	logic [KEY_W-1:0]   l3_rd;
	logic [KEY_W-1:0]   main_rd;
	logic               l1_we;
	logic               l2_we;
	logic               l3_we;
	logic               main_we;
	logic [15:0]        op_a_nxt;
	logic [15:0]        op_b_nxt;
	logic [31:0]        hits1_nxt;
	logic [31:0]        hits2_nxt;
	logic [31:0]        hits3_nxt;

	// The incoming key, trimmed to the stored key width. Zero never matches
	// an empty entry, and keys above the backing store change nothing.
	assign key_in  = cmd.key[KEY_W-1:0];
	assign key_bad = (key_in == '0) || (16'(key_in) > backing_top_q);

	// Only the filled part of each level is walked: the levels fill from
	// entry zero upwards, so the fill count bounds the entries ever written.
	always_comb begin
		unique case (lvl_q)
			LVL_FIRST:  cur_fill = IDX_W'(l1_fill_q);
			LVL_SECOND: cur_fill = IDX_W'(l2_fill_q);
			LVL_THIRD:  cur_fill = IDX_W'(l3_fill_q);
			LVL_MAIN:   cur_fill = IDX_W'(main_fill_q);
			default:    cur_fill = '0;
		endcase
	end

	// The shared comparator sees the entry read in the previous cycle. A hit
	// there stops further reads at once.
	always_comb begin
		unique case (lvl_s1)
			LVL_FIRST:  rd_sel = l1_rd;
			LVL_SECOND: rd_sel = l2_rd;
			LVL_THIRD:  rd_sel = l3_rd;
			LVL_MAIN:   rd_sel = main_rd;
			default:    rd_sel = '0;
		endcase
	end

	assign hit   = v_s1 && (rd_sel == key_q);
	assign issue = (state_q == ST_SCAN) && (idx_q < cur_fill) && !hit;

	// Fill-up: every level above the hit takes the key at its own pointer.
	assign l1_we   = (state_q == ST_UPDATE) && (hit_lvl_q > LVL_FIRST);
	assign l2_we   = (state_q == ST_UPDATE) && (hit_lvl_q > LVL_SECOND);
	assign l3_we   = (state_q == ST_UPDATE) && (hit_lvl_q > LVL_THIRD);
	assign main_we = (state_q == ST_UPDATE) && (hit_lvl_q > LVL_MAIN);

	tflc_ram #(.DEPTH(L1_DEPTH), .WIDTH(KEY_W)) u_l1 (
		.clk   (clk),
		.we    (l1_we),
		.waddr (l1_ptr_q),
		.wdata (key_q),
		.re    (issue && (lvl_q == LVL_FIRST)),
		.raddr (idx_q[L1_AW-1:0]),
		.rdata (l1_rd)
	);

	tflc_ram #(.DEPTH(L2_DEPTH), .WIDTH(KEY_W)) u_l2 (
		.clk   (clk),
		.we    (l2_we),
		.waddr (l2_ptr_q),
		.wdata (key_q),
		.re    (issue && (lvl_q == LVL_SECOND)),
		.raddr (idx_q[L2_AW-1:0]),
		.rdata (l2_rd)
	);

	tflc_ram #(.DEPTH(L3_DEPTH), .WIDTH(KEY_W)) u_l3 (
		.clk   (clk),
		.we    (l3_we),
		.waddr (l3_ptr_q),
		.wdata (key_q),
		.re    (issue && (lvl_q == LVL_THIRD)),
		.raddr (idx_q[L3_AW-1:0]),
		.rdata (l3_rd)
	);

	tflc_ram #(.DEPTH(MAIN_DEPTH), .WIDTH(KEY_W)) u_main (
		.clk   (clk),
		.we    (main_we),
		.waddr (main_ptr_q),
		.wdata (key_q),
		.re    (issue && (lvl_q == LVL_MAIN)),
		.raddr (idx_q[MAIN_AW-1:0]),
		.rdata (main_rd)
	);

	// Values the state takes once a found key has been written back.
	assign op_a_nxt  = func_q ? 16'(key_q) : op_a_q;
	assign op_b_nxt  = func_q ? op_b_q : 16'(key_q);
	assign hits1_nxt = hits1_q + 32'(hit_lvl_q == LVL_FIRST);
	assign hits2_nxt = hits2_q + 32'(hit_lvl_q == LVL_SECOND);
	assign hits3_nxt = hits3_q + 32'(hit_lvl_q == LVL_THIRD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lvl_q         <= LVL_FIRST;
			lvl_s1        <= LVL_FIRST;
			hit_lvl_q     <= LVL_NONE;
			idx_q         <= '0;
			v_s1          <= 1'b0;
			key_q         <= '0;
			func_q        <= 1'b0;
			backing_top_q <= BACKING_TOP_RESET;
			l1_ptr_q      <= '0;
			l2_ptr_q      <= '0;
			l3_ptr_q      <= '0;
			main_ptr_q    <= '0;
			l1_fill_q     <= '0;
			l2_fill_q     <= '0;
			l3_fill_q     <= '0;
			main_fill_q   <= '0;
			op_a_q        <= '0;
			op_b_q        <= '0;
			hits1_q       <= '0;
			hits2_q       <= '0;
			hits3_q       <= '0;
			done_q        <= 1'b0;
			rsp_q         <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue;
			lvl_s1 <= lvl_q;

			if (wr_en) begin
				backing_top_q <= wr_data;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q  <= key_in;
						func_q <= cmd.func;
						if (key_bad) begin
							// Rejected keys are answered straight away and leave
							// every store, pointer and counter as it was.
							done_q            <= 1'b1;
							rsp_q.hit_level   <= LVL_NONE;
							rsp_q.access_time <= access_cost(LVL_NONE);
							rsp_q.operand_sum <= 17'(op_a_q) + 17'(op_b_q);
							rsp_q.hits_first  <= hits1_q;
							rsp_q.hits_second <= hits2_q;
							rsp_q.hits_third  <= hits3_q;
						end else begin
							state_q <= ST_SCAN;
							lvl_q   <= LVL_FIRST;
							idx_q   <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						hit_lvl_q <= lvl_s1;
						state_q   <= ST_UPDATE;
					end else if (issue) begin
						idx_q <= idx_q + IDX_W'(1);
					end else if (lvl_q == LVL_MAIN) begin
						// Nothing held it: the backing store always does.
						hit_lvl_q <= LVL_BACKING;
						state_q   <= ST_UPDATE;
					end else begin
						lvl_q <= hit_level_t'(lvl_q + 3'd1);
						idx_q <= '0;
					end
				end
				ST_UPDATE: begin
					if (l1_we) begin
						l1_ptr_q <= (l1_ptr_q == L1_AW'(L1_DEPTH - 1)) ? '0 :
							l1_ptr_q + L1_AW'(1);
						if (l1_fill_q != L1_FW'(L1_DEPTH)) begin
							l1_fill_q <= l1_fill_q + L1_FW'(1);
						end
					end
					if (l2_we) begin
						l2_ptr_q <= (l2_ptr_q == L2_AW'(L2_DEPTH - 1)) ? '0 :
							l2_ptr_q + L2_AW'(1);
						if (l2_fill_q != L2_FW'(L2_DEPTH)) begin
							l2_fill_q <= l2_fill_q + L2_FW'(1);
						end
					end
					if (l3_we) begin
						l3_ptr_q <= (l3_ptr_q == L3_AW'(L3_DEPTH - 1)) ? '0 :
							l3_ptr_q + L3_AW'(1);
						if (l3_fill_q != L3_FW'(L3_DEPTH)) begin
							l3_fill_q <= l3_fill_q + L3_FW'(1);
						end
					end
					if (main_we) begin
						main_ptr_q <= (main_ptr_q == MAIN_AW'(MAIN_DEPTH - 1)) ?
							'0 : main_ptr_q + MAIN_AW'(1);
						if (main_fill_q != MAIN_FW'(MAIN_DEPTH)) begin
							main_fill_q <= main_fill_q + MAIN_FW'(1);
						end
					end
					op_a_q  <= op_a_nxt;
					op_b_q  <= op_b_nxt;
					hits1_q <= hits1_nxt;
					hits2_q <= hits2_nxt;
					hits3_q <= hits3_nxt;

					done_q            <= 1'b1;
					rsp_q.hit_level   <= hit_lvl_q;
					rsp_q.access_time <= access_cost(hit_lvl_q);
					rsp_q.operand_sum <= 17'(op_a_nxt) + 17'(op_b_nxt);
					rsp_q.hits_first  <= hits1_nxt;
					rsp_q.hits_second <= hits2_nxt;
					rsp_q.hits_third  <= hits3_nxt;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: hw/rtl/tflc_ram.sv
// ----------------------------------------------------------------------------
// tflc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tflc_ram #(
	parameter int DEPTH  = 4,
	parameter int WIDTH  = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/tflc_checker.sv
// ----------------------------------------------------------------------------
// tflc_checker
// Port-level checks on the lookup block, attached by bind.
// ----------------------------------------------------------------------------
`include "three_level_fifo_cache_lookup_assert.svh"

module tflc_checker
	import tflc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_beat_t rsp
);

	// A taken command either starts a search or is answered at once.
	`TFLC_ASSERT_NXT(a_accept_leads_on, start && !busy, busy || done)

	// A search never ends without a result beat.
	`TFLC_ASSERT_IMP(a_search_reports, $fell(busy), done)

	// Result levels stay within the defined codes.
	`TFLC_ASSERT_IMP(a_level_known, done, rsp.hit_level <= LVL_NONE)

	// The reported time always matches the level reported with it.
	`TFLC_ASSERT_IMP(a_time_matches, done, rsp.access_time == access_cost(rsp.hit_level))

endmodule

bind three_level_fifo_cache_lookup tflc_checker u_tflc_checker (.*);
